[hdl/fpa_pkg.sv]
// fpa_pkg: opcodes, widths and shared types for the fixed-point ALU.
// No dependencies; imported by every module under hdl.
`timescale 1ns / 1ps
package fpa_pkg;
	localparam int DATA_W        = 32;
	localparam int FRAC_BITS_DEF = 8;
	localparam int QUEUE_DEPTH   = 4;

	typedef enum logic [3:0] {
		OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
		OP_GT = 4'd4, OP_LT = 4'd5, OP_GE = 4'd6, OP_LE = 4'd7,
		OP_EQ = 4'd8, OP_NE = 4'd9, OP_MIN = 4'd10, OP_MAX = 4'd11,
		OP_INC = 4'd12, OP_DEC = 4'd13, OP_TOINT = 4'd14, OP_FROMINT = 4'd15
	} op_t;

	// Classified item handed from front to back.
	typedef struct packed {
		logic              is_mul;
		logic              is_div;
		logic              dz;
		logic              neg;
		logic [DATA_W-1:0] mag_a;
		logic [DATA_W-1:0] mag_b;
		logic [DATA_W-1:0] simple;
		logic              cmp;
	} item_t;
endpackage

[hdl/fpa_front.sv]
// fpa_front: accepts items, evaluates the simple ops, and prepares
// sign and magnitudes for multiply/divide. Depends on fpa_pkg.
`timescale 1ns / 1ps
module fpa_front
	import fpa_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     valid,
	output logic                     ready,
	input  logic [3:0]               opcode,
	input  logic signed [DATA_W-1:0] operand_a,
	input  logic signed [DATA_W-1:0] operand_b,
	output logic                     item_valid,
	input  logic                     item_ready,
	output item_t                    item
);
	logic  lt_ab, lt_ba, eq_ab;
	item_t nxt;
	logic  vld_s1;
	op_t   op;

	assign op    = op_t'(opcode);
	assign lt_ab = operand_a < operand_b;
	assign lt_ba = operand_b < operand_a;
	assign eq_ab = operand_a == operand_b;

	always_comb begin
		nxt        = '0;
		nxt.is_mul = (op == OP_MUL);
		nxt.is_div = (op == OP_DIV) && (operand_b != '0);
		nxt.dz     = (op == OP_DIV) && (operand_b == '0);
		nxt.neg    = operand_a[DATA_W-1] ^ operand_b[DATA_W-1];
		// magnitude of -2^31 wraps to 2^31 as unsigned, which is correct
		nxt.mag_a  = operand_a[DATA_W-1] ? DATA_W'(-operand_a) : operand_a;
		nxt.mag_b  = operand_b[DATA_W-1] ? DATA_W'(-operand_b) : operand_b;
		case (op)
			OP_ADD:     nxt.simple = operand_a + operand_b;
			OP_SUB:     nxt.simple = operand_a - operand_b;
			OP_GT:      nxt.cmp = lt_ba;
			OP_LT:      nxt.cmp = lt_ab;
			OP_GE:      nxt.cmp = !lt_ab;
			OP_LE:      nxt.cmp = !lt_ba;
			OP_EQ:      nxt.cmp = eq_ab;
			OP_NE:      nxt.cmp = !eq_ab;
			OP_MIN:     nxt.simple = lt_ab ? operand_a : operand_b;
			OP_MAX:     nxt.simple = lt_ba ? operand_a : operand_b;
			OP_INC:     nxt.simple = operand_a + DATA_W'(1);
			OP_DEC:     nxt.simple = operand_a - DATA_W'(1);
			OP_TOINT:   nxt.simple = operand_a >>> FRAC_BITS;
			OP_FROMINT: nxt.simple = operand_a <<< FRAC_BITS;
			default:    nxt.simple = '0;
		endcase
	end

	assign ready      = !vld_s1 || item_ready;
	assign item_valid = vld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (ready) begin
			vld_s1 <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && valid) begin
			item <= nxt;
		end
	end
endmodule

[hdl/fpa_queue.sv]
// fpa_queue: small FIFO that decouples front from back.
// Depends on fpa_pkg.
`timescale 1ns / 1ps
module fpa_queue
	import fpa_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  item_t in_item,
	output logic  out_valid,
	input  logic  out_ready,
	output item_t out_item
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	item_t         mem [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0]   cnt_q;
	logic          push, pop;

	assign in_ready  = cnt_q != (AW+1)'(DEPTH);
	assign out_valid = cnt_q != '0;
	assign out_item  = mem[rd_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == AW'(DEPTH-1)) ? '0 : wr_q + AW'(1);
			if (pop)  rd_q <= (rd_q == AW'(DEPTH-1)) ? '0 : rd_q + AW'(1);
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= in_item;
		end
	end
endmodule

[hdl/fpa_back.sv]
// fpa_back: pipelined multiply and restoring divide, one quotient bit per
// stage, then rounding and saturation. Depends on fpa_pkg.
`timescale 1ns / 1ps
module fpa_back
	import fpa_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  item_t                    in_item,
	output logic                     valid,
	input  logic                     ready,
	output logic signed [DATA_W-1:0] result_raw,
	output logic                     compare_true,
	output logic                     divide_by_zero
);
	localparam int NW = DATA_W + FRAC_BITS;   // dividend width
	localparam int ST = NW + 1;               // divide stages, last takes rounding bit
	localparam int PW = 2 * DATA_W;

	logic          adv;
	logic [ST:0]   vld_q;
	item_t         it_q  [ST+1];
	logic [NW-1:0] num_q [ST+1];
	logic [DATA_W:0] rem_q [ST+1];
	logic [NW:0]   quo_q [ST+1];
	logic [PW-1:0] prod_s1;
	logic [PW-1:0] mq;
	logic [NW:0]   mag;
	logic          out_vld_q;

	assign adv      = !out_vld_q || ready;
	assign in_ready = adv;
	assign valid    = out_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			out_vld_q <= 1'b0;
		end else if (adv) begin
			vld_q     <= {vld_q[ST-1:0], in_valid};
			out_vld_q <= vld_q[ST];
		end
	end

	// stage 0 captures; the multiply is done here, register follows
	always_ff @(posedge clk) begin
		if (adv) begin
			it_q[0]  <= in_item;
			num_q[0] <= NW'(in_item.mag_a) << FRAC_BITS;
			rem_q[0] <= '0;
			quo_q[0] <= '0;
			prod_s1  <= PW'(in_item.mag_a) * PW'(in_item.mag_b);
		end
	end

	// one dividend bit per stage; the final stage yields the half bit
	for (genvar g = 0; g < ST; g++) begin : g_div
		logic [DATA_W+1:0] trial;
		logic [DATA_W+1:0] sh;
		assign sh    = {rem_q[g], num_q[g][NW-1]};
		assign trial = sh - (DATA_W+2)'(it_q[g].mag_b);
		always_ff @(posedge clk) begin
			if (adv) begin
				it_q[g+1]  <= it_q[g];
				num_q[g+1] <= num_q[g] << 1;
				if (!trial[DATA_W+1]) begin
					rem_q[g+1] <= trial[DATA_W:0];
					quo_q[g+1] <= {quo_q[g][NW-1:0], 1'b1};
				end else begin
					rem_q[g+1] <= sh[DATA_W:0];
					quo_q[g+1] <= {quo_q[g][NW-1:0], 1'b0};
				end
			end
		end
	end

	// product delayed alongside the divide pipe
	logic [PW-1:0] pd_q [ST];
	always_ff @(posedge clk) begin
		if (adv) begin
			pd_q[0] <= prod_s1;
			for (int i = 1; i < ST; i++) pd_q[i] <= pd_q[i-1];
		end
	end

	// divide: quotient bit 0 is 2r>=d, so q_rounded = (quo>>1) + quo[0]
	assign mq = (pd_q[ST-1] + ((PW'(1) << FRAC_BITS) >> 1)) >> FRAC_BITS;
	always_comb begin
		mag = '0;
		if (it_q[ST].is_mul) begin
			mag = (mq > PW'({1'b1, {DATA_W{1'b0}}})) ? {1'b1, {NW{1'b0}}} : (NW+1)'(mq);
		end else begin
			mag = (quo_q[ST] >> 1) + (NW+1)'(quo_q[ST][0]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			compare_true   <= it_q[ST].cmp;
			divide_by_zero <= it_q[ST].dz;
			if (it_q[ST].is_mul || it_q[ST].is_div) begin
				if (it_q[ST].neg)
					result_raw <= (mag >= (NW+1)'(33'h1_0000_0000 >> 1)) ?
						{1'b1, {(DATA_W-1){1'b0}}} : -DATA_W'(mag);
				else
					result_raw <= (mag > (NW+1)'({1'b0, {(DATA_W-1){1'b1}}})) ?
						{1'b0, {(DATA_W-1){1'b1}}} : DATA_W'(mag);
			end else begin
				result_raw <= it_q[ST].simple;
			end
		end
	end
endmodule

[hdl/fixed_point_alu.sv]
// Fixed-point ALU top level: front classifier, item queue, pipelined back end.
// Depth: every opcode runs the same back pipe, whose depth the divide sets.
// Throughput: one transfer per cycle unless out_ready stalls the back pipe as a whole.
// Reset: arst_n asynchronously clears all valid and queue pointers.
`timescale 1ns / 1ps
module fixed_point_alu
	import fpa_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [3:0]               opcode,
	input  logic signed [DATA_W-1:0] operand_a,
	input  logic signed [DATA_W-1:0] operand_b,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [DATA_W-1:0] result_raw,
	output logic                     compare_true,
	output logic                     divide_by_zero
);
	item_t f_item, q_item;
	logic  f_vld, f_rdy, q_vld, q_rdy;

	fpa_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk, .arst_n, .valid(in_valid), .ready(in_ready), .opcode, .operand_a,
		.operand_b, .item_valid(f_vld), .item_ready(f_rdy), .item(f_item));

	fpa_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk, .arst_n, .in_valid(f_vld), .in_ready(f_rdy), .in_item(f_item),
		.out_valid(q_vld), .out_ready(q_rdy), .out_item(q_item));

	fpa_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk, .arst_n, .in_valid(q_vld), .in_ready(q_rdy), .in_item(q_item),
		.valid(out_valid), .ready(out_ready), .result_raw, .compare_true,
		.divide_by_zero);
endmodule

[hdl/fpa_checker.sv]
// fpa_checker: port-level checks for fixed_point_alu, bound to the top level.
// Depends on fpa_pkg.
`timescale 1ns / 1ps
module fpa_checker
	import fpa_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_ready,
	input logic [DATA_W-1:0] result_raw,
	input logic              compare_true,
	input logic              divide_by_zero
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_raw))
		else $error("result dropped while stalled");
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(compare_true && divide_by_zero))
		else $error("both flags set");
	a_cmp_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && compare_true |-> result_raw == '0)
		else $error("compare with nonzero result");
	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && divide_by_zero |-> result_raw == '0)
		else $error("divide by zero with nonzero result");
endmodule

bind fixed_point_alu fpa_checker u_fpa_checker (
	.clk, .arst_n, .out_valid, .out_ready, .result_raw, .compare_true, .divide_by_zero);

[tb/tb_fixed_point_alu.sv]
// Testbench for fixed_point_alu: random and directed opcodes, predicted results compared in order.
// Depends on fpa_pkg and the fixed_point_alu RTL.
`timescale 1ns / 1ps
module tb_fixed_point_alu;
	import fpa_pkg::*;

	localparam int FB = FRAC_BITS_DEF;
	localparam int LATENCY = FB + 36;
	localparam int STALL_LIMIT = 4000;

	typedef struct {
		logic [3:0]  op;
		logic [31:0] a;
		logic [31:0] b;
	} alu_req_t;

	typedef struct {
		logic [31:0] res;
		logic        cmp;
		logic        dz;
	} alu_res_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [3:0] opcode;
	logic signed [31:0] operand_a;
	logic signed [31:0] operand_b;
	logic out_valid;
	logic out_ready;
	logic signed [31:0] result_raw;
	logic compare_true;
	logic divide_by_zero;

	alu_req_t req_q[$];
	alu_res_t expected_q[$];
	int send_idle_pct;
	int recv_idle_pct;
	int errors;
	int quiet_cycles;

	fixed_point_alu #(.FRAC_BITS(FB)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.opcode(opcode), .operand_a(operand_a), .operand_b(operand_b),
		.out_valid(out_valid), .out_ready(out_ready),
		.result_raw(result_raw), .compare_true(compare_true),
		.divide_by_zero(divide_by_zero)
	);

	function automatic logic [63:0] magnitude(logic [31:0] v);
		if (v[31])
			return {32'd0, -v};
		return {32'd0, v};
	endfunction

	function automatic logic [31:0] saturate(logic neg, logic [63:0] m);
		if (neg)
			return (m >= 64'h8000_0000) ? 32'h8000_0000 : -m[31:0];
		return (m > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
	endfunction

	function automatic alu_res_t predict_alu(alu_req_t r);
		alu_res_t o;
		logic neg;
		logic [63:0] m;
		logic [63:0] d;
		logic [63:0] q;
		logic [63:0] rem;
		logic signed [31:0] sa;
		logic signed [31:0] sb;
		o = '{res: 32'd0, cmp: 1'b0, dz: 1'b0};
		neg = r.a[31] ^ r.b[31];
		sa = r.a;
		sb = r.b;
		case (op_t'(r.op))
			OP_ADD: o.res = r.a + r.b;
			OP_SUB: o.res = r.a - r.b;
			OP_MUL: begin
				m = magnitude(r.a) * magnitude(r.b);
				q = (m + ((64'd1 << FB) >> 1)) >> FB;
				o.res = saturate(neg, q);
			end
			OP_DIV: begin
				if (r.b == 0) begin
					o.dz = 1'b1;
				end else begin
					d = magnitude(r.b);
					m = magnitude(r.a) << FB;
					q = m / d;
					rem = m % d;
					if (2 * rem >= d)
						q++;
					o.res = saturate(neg, q);
				end
			end
			OP_GT: o.cmp = sa > sb;
			OP_LT: o.cmp = sa < sb;
			OP_GE: o.cmp = sa >= sb;
			OP_LE: o.cmp = sa <= sb;
			OP_EQ: o.cmp = r.a == r.b;
			OP_NE: o.cmp = r.a != r.b;
			OP_MIN: o.res = (sa < sb) ? r.a : r.b;
			OP_MAX: o.res = (sb < sa) ? r.a : r.b;
			OP_INC: o.res = r.a + 1;
			OP_DEC: o.res = r.a - 1;
			OP_TOINT: o.res = sa >>> FB;
			default: o.res = r.a << FB;
		endcase
		return o;
	endfunction

	// Operand drawn mostly from small or edge values so rounding and saturation get hit.
	function automatic logic [31:0] pick_operand();
		case ($urandom_range(0, 5))
			0: return $urandom();
			1: return $urandom_range(0, 1023) - 512;
			2: return 32'h8000_0000 + $urandom_range(0, 3);
			3: return 32'h7FFF_FFFF - $urandom_range(0, 3);
			4: return $urandom_range(0, 3) - 1;
			default: return ($urandom() >> $urandom_range(0, 31)) ^ {32{$urandom_range(0, 1) == 1}};
		endcase
	endfunction

	task automatic push_req(logic [3:0] op, logic [31:0] a, logic [31:0] b);
		alu_req_t r;
		r = '{op: op, a: a, b: b};
		req_q.push_back(r);
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			opcode <= '0;
			operand_a <= '0;
			operand_b <= '0;
		end else if (!in_valid || in_ready) begin
			if (in_valid)
				expected_q.push_back(predict_alu('{op: opcode, a: operand_a, b: operand_b}));
			if (req_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				alu_req_t r;
				r = req_q.pop_front();
				in_valid <= 1'b1;
				opcode <= r.op;
				operand_a <= r.a;
				operand_b <= r.b;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Monitor and receiver stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					$error("unexpected result %h", result_raw);
					errors++;
				end else begin
					alu_res_t e;
					e = expected_q.pop_front();
					if (result_raw !== e.res) begin
						$error("result_raw exp %h got %h", e.res, result_raw);
						errors++;
					end
					if (compare_true !== e.cmp) begin
						$error("compare_true exp %b got %b", e.cmp, compare_true);
						errors++;
					end
					if (divide_by_zero !== e.dz) begin
						$error("divide_by_zero exp %b got %b", e.dz, divide_by_zero);
						errors++;
					end
				end
			end
			out_ready <= $urandom_range(0, 99) >= recv_idle_pct;
		end
	end

	// Watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	initial begin
		logic [31:0] edges[6];
		int n;
		edges = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h100};
		errors = 0;
		quiet_cycles = 0;
		send_idle_pct = 34;
		recv_idle_pct = 71;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Every opcode on edge pairs, then the named special cases.
		for (int op = 0; op < 16; op++)
			push_req(op[3:0], edges[op % 6], edges[(op + 3) % 6]);
		push_req(OP_DIV, 32'h100, 32'h0);
		push_req(OP_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
		push_req(OP_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		push_req(OP_MUL, 32'h80, 32'h1);
		push_req(OP_MUL, 32'hFFFF_FF80, 32'h1);
		push_req(OP_MIN, 32'h55, 32'h55);
		push_req(OP_MAX, 32'h8000_0000, 32'h8000_0000);
		push_req(OP_TOINT, 32'hFFFF_FFFF, 32'h0);
		push_req(OP_FROMINT, 32'h00FF_FFFF, 32'h0);

		for (n = 0; n < 1100; n++) begin
			logic [31:0] b;
			b = ($urandom_range(0, 15) == 0) ? 32'h0 : pick_operand();
			push_req(4'($urandom_range(0, 15)), pick_operand(), b);
		end

		wait (req_q.size() < 733);
		send_idle_pct = 71;
		recv_idle_pct = 34;
		wait (req_q.size() < 366);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		wait (req_q.size() == 0);
		@(posedge clk);
		while (in_valid || expected_q.size() > 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (errors == 0 && !out_valid)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
